>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet while
// i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Request and response types, opcodes and status codes of the frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    localparam int INDEX_W = 16;
    localparam int COUNT_W = 17;

    localparam logic [COUNT_W-1:0] FRAMES_RESET = 17'd65536;

    typedef enum logic [1:0] {
        OP_FREE      = 2'd0,
        OP_LOCK      = 2'd1,
        OP_ALLOC_ONE = 2'd2,
        OP_ALLOC_RUN = 2'd3
    } t_bfa_op;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_RANGE  = 2'd2
    } t_bfa_status;

    typedef struct packed {
        t_bfa_op              opcode;
        logic [INDEX_W-1:0]   frame_index;
        logic [COUNT_W-1:0]   run_length;
    } t_bfa_req;

    typedef struct packed {
        t_bfa_status          status;
        logic [INDEX_W-1:0]   result_index;
        logic [COUNT_W-1:0]   free_count;
        logic [COUNT_W-1:0]   locked_count;
    } t_bfa_rsp;

endpackage

`default_nettype wire

>>> rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page-frame allocator over a one-bit-per-frame lock map held in a single
// port-style memory, scanned one word at a time by a shared bit-scan unit.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Handshake                    Payload
// request   in    start, busy                  i_req  (t_bfa_req)
// result    out   o_rsp_valid, one-cycle       o_rsp  (t_bfa_rsp)
// config    in    i_cfg_valid, o_cfg_ready     i_cfg_data (frames in use)
//
// Free and lock step through split, read, modify and respond (respond only when out of
// range; a zero-length run also responds only); the result strobe follows in the cycle
// busy drops, and the next start may be taken then. Allocations read and scan each map
// word below the limit from the hint word, scan again at each free/locked boundary met,
// read and write each word locked and respond, or respond straight after the read that
// runs off the limit. After reset the map is swept to all locked, one word per cycle, with
// busy high; config writes are taken throughout. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bitmap_frame_allocator #(
    parameter int MAX_FRAMES    = 65536,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire bfa_pkg::t_bfa_req              i_req,
    output logic                                o_rsp_valid,
    output bfa_pkg::t_bfa_rsp                   o_rsp,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bfa_pkg::COUNT_W-1:0]    i_cfg_data
);
    import bfa_pkg::*;

    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(MAP_WORD_BITS);
    localparam int CW        = $clog2(MAX_FRAMES + 1);
    localparam int LW        = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [AW-1:0] LAST_WORD  = AW'(MAP_WORDS - 1);
    localparam logic [LW-1:0] WORD_STEP  = LW'(MAP_WORD_BITS);
    localparam logic [CW-1:0] FRAMES_CAP = CW'(MAX_FRAMES);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_IDX_READ,
        S_IDX_MOD,
        S_SCAN_READ,
        S_FIND,
        S_LOCK_READ,
        S_LOCK_WRITE,
        S_RESP
    } t_state;

    // control state
    t_state              r_state;
    logic [AW-1:0]       r_clr_addr;
    logic [COUNT_W-1:0]  r_frames;
    logic [CW-1:0]       r_free_total;
    logic [AW-1:0]       r_hint_word;
    logic [LW-1:0]       r_hint_base;
    logic [BW-1:0]       r_hint_bit;
    logic                r_rsp_valid;

    // per-request working registers
    t_bfa_op             r_op;
    logic [INDEX_W-1:0]  r_idx;
    logic [LW-1:0]       r_len;
    logic [LW-1:0]       r_run;
    logic [AW-1:0]       r_word;
    logic [LW-1:0]       r_base;
    logic [BW-1:0]       r_pos;
    logic                r_in_run;
    logic [AW-1:0]       r_rs_word;
    logic [LW-1:0]       r_rs_base;
    logic [BW-1:0]       r_rs_bit;
    logic [LW-1:0]       r_remain;
    t_bfa_status         r_status;
    logic [INDEX_W-1:0]  r_result;
    t_bfa_rsp            r_rsp;

    // lock map
    logic [MAP_WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] r_rdata;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;

    logic [CW-1:0]            limit;
    logic [CW-1:0]            locked_now;
    logic [LW-1:0]            valid_cnt;
    logic [MAP_WORD_BITS-1:0] valid_mask;
    logic [MAP_WORD_BITS-1:0] eff_word;
    logic                     sc_found;
    logic [BW-1:0]            sc_bit;
    logic [LW-1:0]            seg_end;
    logic [LW-1:0]            run_next;
    logic                     run_fit;
    logic [LW-1:0]            avail;
    logic [LW-1:0]            lock_n;
    logic [MAP_WORD_BITS-1:0] fill;
    logic [MAP_WORD_BITS-1:0] lock_mask;
    logic [AW-1:0]            sp_word;
    logic [BW-1:0]            sp_bit;
    logic                     cur_locked;
    logic [MAP_WORD_BITS-1:0] idx_wdata;

    bfa_index_split #(
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .WORD_AW       (AW)
    ) u_split (
        .i_clk   (i_clk),
        .i_index (r_idx),
        .o_word  (sp_word),
        .o_bit   (sp_bit)
    );

    bfa_bitscan #(
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_scan (
        .i_word        (eff_word),
        .i_pos         (r_pos),
        .i_find_locked (r_in_run),
        .o_found       (sc_found),
        .o_bit         (sc_bit)
    );

    always_comb begin
        limit = (LW'(r_frames) > LW'(FRAMES_CAP)) ? FRAMES_CAP : CW'(r_frames);
        locked_now = (limit > r_free_total) ? (limit - r_free_total) : '0;

        // frames at or above the limit look locked to the scan
        valid_cnt = LW'(limit) - r_base;
        if (valid_cnt >= WORD_STEP) begin
            valid_mask = '1;
        end else begin
            valid_mask = (MAP_WORD_BITS'(1) << valid_cnt[BW-1:0]) - MAP_WORD_BITS'(1);
        end
        eff_word = r_rdata | ~valid_mask;

        seg_end  = sc_found ? LW'(sc_bit) : WORD_STEP;
        run_next = r_run + seg_end - LW'(r_pos);
        run_fit  = (run_next >= r_len);

        avail  = WORD_STEP - LW'(r_pos);
        lock_n = (r_remain < avail) ? r_remain : avail;
        if (lock_n >= WORD_STEP) begin
            fill = '1;
        end else begin
            fill = (MAP_WORD_BITS'(1) << lock_n[BW-1:0]) - MAP_WORD_BITS'(1);
        end
        lock_mask = fill << r_pos;

        cur_locked        = r_rdata[sp_bit];
        idx_wdata         = r_rdata;
        idx_wdata[sp_bit] = (r_op == OP_LOCK);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_word;
        mem_wdata = r_rdata | lock_mask;
        mem_re    = 1'b0;
        mem_raddr = r_word;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '1;
            end
            S_IDX_READ: begin
                mem_re    = 1'b1;
                mem_raddr = sp_word;
            end
            S_IDX_MOD: begin
                mem_we    = 1'b1;
                mem_waddr = sp_word;
                mem_wdata = idx_wdata;
            end
            S_SCAN_READ, S_LOCK_READ: begin
                mem_re = 1'b1;
            end
            S_LOCK_WRITE: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_map[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_frames     <= FRAMES_RESET;
            r_free_total <= '0;
            r_hint_word  <= '0;
            r_hint_base  <= '0;
            r_hint_bit   <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_rsp_valid <= (r_state == S_RESP);
            if (i_cfg_valid && o_cfg_ready) begin
                r_frames <= i_cfg_data;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_req.opcode;
                        r_idx    <= i_req.frame_index;
                        r_in_run <= 1'b0;
                        r_run    <= '0;
                        r_word   <= r_hint_word;
                        r_base   <= r_hint_base;
                        r_pos    <= r_hint_bit;
                        r_len    <= (i_req.opcode == OP_ALLOC_ONE) ? LW'(1)
                                                                   : LW'(i_req.run_length);
                        unique case (i_req.opcode)
                            OP_FREE, OP_LOCK: begin
                                r_result <= i_req.frame_index;
                                if (LW'(i_req.frame_index) >= LW'(limit)) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_state  <= S_SPLIT;
                                end
                            end
                            OP_ALLOC_ONE: begin
                                r_result <= '0;
                                r_status <= ST_DONE;
                                r_state  <= S_SCAN_READ;
                            end
                            OP_ALLOC_RUN: begin
                                r_result <= '0;
                                if (i_req.run_length == '0) begin
                                    r_status <= ST_NO_FIT;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_state  <= S_SCAN_READ;
                                end
                            end
                        endcase
                    end
                end

                S_SPLIT: begin
                    r_state <= S_IDX_READ;
                end

                S_IDX_READ: begin
                    r_state <= S_IDX_MOD;
                end

                S_IDX_MOD: begin
                    if (r_op == OP_FREE && cur_locked) begin
                        r_free_total <= r_free_total + 1'b1;
                    end else if (r_op == OP_LOCK && !cur_locked) begin
                        r_free_total <= r_free_total - 1'b1;
                    end
                    r_state <= S_RESP;
                end

                S_SCAN_READ: begin
                    if (LW'(limit) <= r_base) begin
                        r_status <= ST_NO_FIT;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_FIND;
                    end
                end

                S_FIND: begin
                    if (!r_in_run) begin
                        if (sc_found) begin
                            // start of a free segment
                            r_in_run  <= 1'b1;
                            r_pos     <= sc_bit;
                            r_run     <= '0;
                            r_rs_word <= r_word;
                            r_rs_base <= r_base;
                            r_rs_bit  <= sc_bit;
                        end else begin
                            r_word  <= r_word + 1'b1;
                            r_base  <= r_base + WORD_STEP;
                            r_pos   <= '0;
                            r_state <= S_SCAN_READ;
                        end
                    end else if (run_fit) begin
                        // every frame of the run is free, so the count drops by the length
                        r_free_total <= r_free_total - CW'(r_len);
                        r_result     <= INDEX_W'(r_rs_base + LW'(r_rs_bit));
                        if (r_op == OP_ALLOC_ONE) begin
                            r_hint_word <= r_rs_word;
                            r_hint_base <= r_rs_base;
                            r_hint_bit  <= r_rs_bit;
                        end
                        r_word   <= r_rs_word;
                        r_pos    <= r_rs_bit;
                        r_remain <= r_len;
                        r_state  <= S_LOCK_READ;
                    end else if (sc_found) begin
                        // segment too short: resume the free search at the locked bit
                        r_in_run <= 1'b0;
                        r_pos    <= sc_bit;
                        r_run    <= '0;
                    end else begin
                        r_run   <= run_next;
                        r_word  <= r_word + 1'b1;
                        r_base  <= r_base + WORD_STEP;
                        r_pos   <= '0;
                        r_state <= S_SCAN_READ;
                    end
                end

                S_LOCK_READ: begin
                    r_state <= S_LOCK_WRITE;
                end

                S_LOCK_WRITE: begin
                    r_remain <= r_remain - lock_n;
                    if (r_remain == lock_n) begin
                        r_state <= S_RESP;
                    end else begin
                        r_word  <= r_word + 1'b1;
                        r_pos   <= '0;
                        r_state <= S_LOCK_READ;
                    end
                end

                S_RESP: begin
                    r_rsp.status       <= r_status;
                    r_rsp.result_index <= r_result;
                    r_rsp.free_count   <= COUNT_W'(r_free_total);
                    r_rsp.locked_count <= COUNT_W'(locked_now);
                    r_state            <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

    `BFA_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
    `BFA_ASSERT_NEXT(a_rsp_single_cycle, o_rsp_valid, !o_rsp_valid)
    `BFA_ASSERT_NOW(a_no_fit_zero_index, o_rsp_valid && (o_rsp.status == ST_NO_FIT), o_rsp.result_index == '0)
    `BFA_ASSERT_NOW(a_lock_pass_nonempty, r_state == S_LOCK_WRITE, r_remain != '0)

endmodule

`default_nettype wire

>>> rtl/bfa_index_split.sv
// ----------------------------------------------------------------------------
// bfa_index_split
// Splits a frame index into map word address and bit offset. The quotient
// comes from a reciprocal multiply, the offset from a back-multiply one
// stage later. The word is registered from the index, the offset from the registered word.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_index_split #(
    parameter int MAP_WORD_BITS = 64,
    parameter int WORD_AW       = 10
) (
    input  wire logic                                  i_clk,
    input  wire logic [bfa_pkg::INDEX_W-1:0]           i_index,
    output logic      [WORD_AW-1:0]                    o_word,
    output logic      [$clog2(MAP_WORD_BITS)-1:0]      o_bit
);
    import bfa_pkg::*;

    localparam int BW    = $clog2(MAP_WORD_BITS);
    localparam int SH    = INDEX_W + BW;
    localparam int RECIP = ((1 << SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = INDEX_W + RW;

    logic [PW-1:0]      prod;
    logic [INDEX_W-1:0] rem;

    logic [WORD_AW-1:0] r_word;
    logic [INDEX_W-1:0] r_index;
    logic [BW-1:0]      r_bit;

    // exact quotient for every 16-bit index with this rounding of the reciprocal
    assign prod = PW'(i_index) * PW'(RECIP);
    assign rem  = r_index - (INDEX_W'(r_word) * INDEX_W'(MAP_WORD_BITS));

    always_ff @(posedge i_clk) begin
        r_word  <= WORD_AW'(prod >> SH);
        r_index <= i_index;
        r_bit   <= BW'(rem);
    end

    assign o_word = r_word;
    assign o_bit  = r_bit;

endmodule

`default_nettype wire

>>> rtl/bfa_bitscan.sv
// ----------------------------------------------------------------------------
// bfa_bitscan
// Shared scan unit: finds the lowest free or locked bit of a map word at or
// above a start offset.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_bitscan #(
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic [MAP_WORD_BITS-1:0]          i_word,
    input  wire logic [$clog2(MAP_WORD_BITS)-1:0]  i_pos,
    input  wire logic                              i_find_locked,
    output logic                                   o_found,
    output logic      [$clog2(MAP_WORD_BITS)-1:0]  o_bit
);
    localparam int BW = $clog2(MAP_WORD_BITS);

    logic [MAP_WORD_BITS-1:0] cand;
    logic [MAP_WORD_BITS-1:0] lowest;
    logic [BW-1:0]            enc;

    always_comb begin
        cand   = (i_find_locked ? i_word : ~i_word) & ({MAP_WORD_BITS{1'b1}} << i_pos);
        // isolate the lowest set bit, then encode the one-hot result
        lowest = cand & (~cand + MAP_WORD_BITS'(1));
        enc    = '0;
        for (int j = 0; j < MAP_WORD_BITS; j++) begin
            if (lowest[j]) begin
                enc = enc | BW'(j);
            end
        end
    end

    assign o_found = |cand;
    assign o_bit   = enc;

endmodule

`default_nettype wire
